### hw/rtl/isc_pkg.sv
// Shared constants for the independent set check unit.
// Holds operation codes and field widths; depends on nothing else.
`default_nettype none

package isc_pkg;

   // Field widths of the request, response and configuration register.
   localparam int ROW_W    = 64;
   localparam int INDEX_W  = 6;
   localparam int VCOUNT_W = 7;

   // Operation codes carried in the request.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // Vertex count after reset.
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage : isc_pkg

`default_nettype wire

### hw/rtl/isc_if.sv
// Channel interfaces of the independent set check unit.
// Depends on isc_pkg for field widths.
`default_nettype none

// Request channel: one row load or one set check per transfer.
interface isc_req_if
   import isc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [INDEX_W-1:0] row_index;
   logic [ROW_W-1:0]   row_bits;
   logic [ROW_W-1:0]   set_mask;

   modport source (output valid, operation, row_index, row_bits, set_mask, input ready);
   modport sink   (input valid, operation, row_index, row_bits, set_mask, output ready);
endinterface : isc_req_if

// Response channel: the two flags of one set check per transfer.
interface isc_rsp_if;
   logic valid;
   logic ready;
   logic is_independent;
   logic is_maximal;

   modport source (output valid, is_independent, is_maximal, input ready);
   modport sink   (input valid, is_independent, is_maximal, output ready);
endinterface : isc_rsp_if

`default_nettype wire

### hw/rtl/independent_set_check_unit.sv
// Independent set check unit: adjacency memory, row sweep and flag logic.
// Depends on isc_pkg and the channel interfaces in isc_if.sv.
//
// Usage:
//   The request channel carries either a row load or a set check. A load
//   writes one adjacency row into the row memory in its transfer cycle and
//   gives no response. A check latches the set, masked to the vertices in
//   use, then reads every row of the memory, one row per cycle through its
//   single read port, and gives one response with the two flags.
//   A check holds off new requests through the sweep, drain and finish states;
//   the next request is taken once the sequencer is back in idle, from the
//   cycle in which the response becomes valid. A load leaves the sequencer
//   idle, so loads do not hold off requests.
//   The response sits in an output register. A new request is taken while it
//   waits; a check that finishes while the old response is still held waits
//   for the receiver before it overwrites the register.
//   At reset the row memory reads as all zero (a valid bit per row, cleared
//   at once), the vertex count returns to 64 and no response is pending.
//   Write the vertex count (csr_we, csr_wdata) only while idle; not enforced.
`default_nettype none

module independent_set_check_unit
   import isc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   isc_req_if.sink                  req_ch,
   isc_rsp_if.source                rsp_ch,
   input  wire logic                csr_we,
   input  wire logic [VCOUNT_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);
   localparam logic [VCOUNT_W-1:0] MAX_VCOUNT = VCOUNT_W'(MAX_VERTICES);

   // Sequencer state codes.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [VCOUNT_W-1:0] vcount_ff;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                proc_vld_ff;
   logic [ADDR_W-1:0]   proc_addr_ff;
   logic [ROW_W-1:0]    rd_data_ff;
   logic                rd_ok_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [ROW_W-1:0]    row_mem [MAX_VERTICES];
   logic [ROW_W-1:0]    used_ff, set_ff, reach_ff, blk_ff;
   logic                rsp_valid_ff, rsp_indep_ff, rsp_max_ff;

   logic [VCOUNT_W-1:0] vcount_sat;
   logic [ROW_W-1:0]    used_c;
   logic [ROW_W-1:0]    row_c;
   logic                req_xfer, load_xfer, check_xfer, load_ok;
   logic                indep_c, maximal_c, rsp_free;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_we) begin
         vcount_ff <= csr_wdata;
      end
   end

   // Mask of the vertices in use, with the count saturated to the memory depth.
   always_comb begin
      vcount_sat = (vcount_ff > MAX_VCOUNT) ? MAX_VCOUNT : vcount_ff;
      for (int j = 0; j < ROW_W; j++) begin
         used_c[j] = (VCOUNT_W'(j) < vcount_sat);
      end
   end

   // Request handshake: requests are taken only while the sequencer is idle.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign load_xfer    = req_xfer && (req_ch.operation == OP_LOAD);
   assign check_xfer   = req_xfer && (req_ch.operation == OP_CHECK);
   assign load_ok      = ({1'b0, req_ch.row_index} < (INDEX_W + 1)'(MAX_VERTICES));
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Row memory: written by loads, read one row per cycle by the sweep.
   always_ff @(posedge clock) begin
      if (load_xfer && load_ok) begin
         row_mem[req_ch.row_index[ADDR_W-1:0]] <= req_ch.row_bits;
      end
      rd_data_ff <= row_mem[rd_addr_ff];
   end

   // Per-row valid bits: a row never loaded since reset reads as no edges.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (load_xfer && load_ok) begin
            row_valid_ff[req_ch.row_index[ADDR_W-1:0]] <= 1'b1;
         end
         rd_ok_ff <= row_valid_ff[rd_addr_ff];
      end
   end

   // Sequencer next state and read address.
   always_comb begin
      state_in   = state_ff;
      rd_addr_in = rd_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr_in = '0;
            if (check_xfer) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (rd_addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_addr_ff  <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_addr_ff  <= rd_addr_in;
         proc_vld_ff <= (state_ff == ST_SWEEP);
      end
   end

   // The row arriving from memory, restricted to the vertices in use.
   assign row_c = rd_ok_ff ? (rd_data_ff & used_ff) : '0;

   // Accumulate the reach of the members and the blocked outside vertices.
   always_ff @(posedge clock) begin
      proc_addr_ff <= rd_addr_ff;
      if (check_xfer) begin
         used_ff  <= used_c;
         set_ff   <= req_ch.set_mask & used_c;
         reach_ff <= '0;
         blk_ff   <= '0;
      end else if (proc_vld_ff) begin
         if (set_ff[proc_addr_ff]) begin
            reach_ff <= reach_ff | row_c;
         end
         if (((row_c & set_ff) != '0) || row_c[proc_addr_ff]) begin
            blk_ff[proc_addr_ff] <= 1'b1;
         end
      end
   end

   // Final flags once every row has been seen.
   always_comb begin
      indep_c   = ((reach_ff & set_ff) == '0);
      maximal_c = indep_c &&
                  (((used_ff & ~set_ff) & ~(reach_ff | blk_ff)) == '0);
   end

   // Response register: loaded at the end of a check once the previous
   // response has been transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_indep_ff <= indep_c;
         rsp_max_ff   <= maximal_c;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.is_independent = rsp_indep_ff;
   assign rsp_ch.is_maximal     = rsp_max_ff;

   // The sweep steps through the rows one address per cycle.
   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && rd_addr_ff != LAST_ADDR) |=>
         (state_ff == ST_SWEEP && rd_addr_ff == $past(rd_addr_ff) + 1'b1))
      else $error("sweep address did not advance by one");

   // Memory data is only consumed during the sweep or the cycle after it.
   a_proc_window: assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("row processed outside the sweep");

   // A maximal set is always independent.
   a_max_implies_indep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_indep_ff || !rsp_max_ff))
      else $error("maximal flag set without independence");

   // A finishing check never overwrites a response still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_indep_ff) && $stable(rsp_max_ff))
      else $error("pending response overwritten");

endmodule : independent_set_check_unit

`default_nettype wire
